@@ rtl/alrp_pkg.sv @@
// ----------------------------------------------------------------------------
// alrp_pkg: shared types and constants for the audio looper
// Holds field widths, the default store depth and the mode codes.
// ----------------------------------------------------------------------------
package alrp_pkg;

  localparam int CMD_W       = 2;
  localparam int SAMPLE_W    = 32;
  localparam int POS_OUT_W   = 17;
  localparam int LOOP_DEPTH_DEFAULT = 65536;

  typedef enum logic [CMD_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2,
    MODE_DUB  = 2'd3
  } mode_t;

endpackage

@@ rtl/alrp_if.sv @@
// ----------------------------------------------------------------------------
// alrp_if: stream channels of the audio looper
// One channel carries command and input sample, the other the result.
// ----------------------------------------------------------------------------
interface alrp_in_if
  import alrp_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SAMPLE_W-1:0] sample_in;

  modport source (output valid, command, sample_in, input ready);
  modport sink   (input valid, command, sample_in, output ready);
endinterface

interface alrp_out_if
  import alrp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  sample_out;
  logic                 out_valid;
  logic [POS_OUT_W-1:0] position;
  logic [POS_OUT_W-1:0] length_now;

  modport source (output valid, sample_out, out_valid, position, length_now, input ready);
  modport sink   (input valid, sample_out, out_valid, position, length_now, output ready);
endinterface

@@ rtl/audio_loop_record_play_core.sv @@
// ----------------------------------------------------------------------------
// audio_loop_record_play_core: per-sample record, play and overdub looper
// Each result passes stage one (store read) and then the output register.
// Throughput: one transaction per cycle unless the result channel stalls;
// one registered store read and write per cycle, read first on the same entry.
// Reset clears position, loop length, previous mode and the pipeline valids.
// The loop store is not cleared; entries are meaningful once written.
// ----------------------------------------------------------------------------
module audio_loop_record_play_core
  import alrp_pkg::*;
#(
  parameter int LOOP_DEPTH = LOOP_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  alrp_in_if.sink        feed,
  alrp_out_if.source     result
);

  // The position counts up to and holds at LOOP_DEPTH, so it needs one more
  // value than the store has entries.
  localparam int POS_W  = $clog2(LOOP_DEPTH + 1);
  localparam int ADDR_W = $clog2(LOOP_DEPTH);
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(LOOP_DEPTH);

  // Control state, updated once per accepted transaction.
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] size, size_next;
  mode_t            prev_mode;

  // Loop store: one synchronous write port, one registered read port.
  logic [SAMPLE_W-1:0] loop_store [LOOP_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;

  // Stage one holds metadata alongside the memory read in flight; stage two
  // is the output register.
  logic                 s1_v, s1_gate, s1_vld;
  logic [POS_OUT_W-1:0] s1_pos, s1_len;
  logic                 s2_v;
  logic [SAMPLE_W-1:0]  s2_sample;
  logic                 s2_vld;
  logic [POS_OUT_W-1:0] s2_pos, s2_len;

  logic       in_acc, s1_adv;
  mode_t      mode;
  logic [POS_W-1:0] pos_a, pos_inc;
  logic       in_range, play_vld, wr_en;
  logic [ADDR_W-1:0] addr;

  // Stage one may move on when the output register is empty or drained this
  // cycle; a new transaction enters whenever stage one is free or moving.
  assign s1_adv     = !s2_v || result.ready;
  assign feed.ready = !s1_v || s1_adv;
  assign in_acc     = feed.valid && feed.ready;
  assign mode       = mode_t'(feed.command);

  // Mode transitions act on the state before the sample is handled. Idle to
  // record restarts the take; record to play latches the recorded length.
  always_comb begin
    pos_a     = pos;
    size_next = size;
    if (mode == MODE_REC && prev_mode == MODE_IDLE) begin
      pos_a = '0;
    end else if (mode == MODE_PLAY && prev_mode == MODE_REC) begin
      size_next = pos;
      pos_a     = '0;
    end
  end

  // The position only ever reaches the store depth and then stays there, so
  // inequality with the depth is the in-range test.
  assign in_range = (pos_a != DEPTH_POS);
  assign play_vld = (mode == MODE_PLAY || mode == MODE_DUB) && (size_next != '0);
  assign wr_en    = in_acc && (mode == MODE_REC || mode == MODE_DUB) && in_range;
  assign addr     = pos_a[ADDR_W-1:0];

  // Advance, hold at the end of the store, and wrap at a nonzero loop length
  // in every mode other than record.
  always_comb begin
    pos_inc = in_range ? pos_a + POS_W'(1) : pos_a;
    if (mode != MODE_REC && size_next != '0 && pos_inc >= size_next) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      size      <= '0;
      prev_mode <= MODE_IDLE;
    end else if (in_acc) begin
      pos       <= pos_next;
      size      <= size_next;
      prev_mode <= mode;
    end
  end

  // Read-first behavior: the read samples the old word even when the same
  // entry is written in this cycle. A later transaction reads after the write
  // has landed, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= loop_store[addr];
    end
    if (wr_en) begin
      loop_store[addr] <= feed.sample_in;
    end
  end

  // Stage one control and metadata.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (feed.ready) begin
      s1_v <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gate <= play_vld && in_range;
      s1_vld  <= play_vld;
      s1_pos  <= POS_OUT_W'(pos_next);
      s1_len  <= POS_OUT_W'(size_next);
    end
  end

  // Output register. A read past the store end gives a silent word while the
  // valid flag still follows the loop length.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v) begin
      s2_sample <= s1_gate ? rd_data : '0;
      s2_vld    <= s1_vld;
      s2_pos    <= s1_pos;
      s2_len    <= s1_len;
    end
  end

  assign result.valid      = s2_v;
  assign result.sample_out = s2_sample;
  assign result.out_valid  = s2_vld;
  assign result.position   = s2_pos;
  assign result.length_now = s2_len;

  // A held stage one must block the input channel.
  assert property (@(posedge clk) disable iff (rst)
    s1_v && !s1_adv |-> !in_acc)
    else $error("transaction accepted while stage one is stalled");

  // The position never runs past the store end.
  assert property (@(posedge clk) disable iff (rst)
    pos <= DEPTH_POS)
    else $error("position beyond store depth");

  // The loop length changes only on a record to play transition.
  assert property (@(posedge clk) disable iff (rst)
    in_acc && !(mode == MODE_PLAY && prev_mode == MODE_REC) |=> size == $past(size))
    else $error("loop length changed outside record to play");

  // A silent result carries a zero word.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.out_valid |-> result.sample_out == '0)
    else $error("nonzero sample with out_valid low");

endmodule
